[rtl/core/sfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants of the sparse feature accumulator
// Command codes, field widths, default sizes and the controller command bundle.
// ----------------------------------------------------------------------------
package sfa_pkg;

	localparam int FEATURES_DEF = 768;
	localparam int LANES_DEF    = 16;
	localparam int SLOTS_DEF    = 8;

	localparam int CMD_W     = 3;
	localparam int FEATURE_W = 10;
	localparam int LANE_W    = 4;
	localparam int SLOT_W    = 3;
	localparam int DATA_W    = 16;

	localparam logic [CMD_W-1:0] CMD_LD_WEIGHT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LD_BIAS   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REFRESH   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SUB       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COPY      = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

	// address width of a store, at least one bit
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic latch;  // capture the request fields
		logic load;   // single-lane store write and result
		logic rd;     // sweep read of one lane
	} ctl_t;

endpackage
`default_nettype wire

[rtl/core/sfa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [sfa_pkg::addr_w(DEPTH)-1:0]    waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [sfa_pkg::addr_w(DEPTH)-1:0]    raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/sfa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_ctrl: request sequencer
// Accepts requests, runs the load path or the per-lane sweep.
// ----------------------------------------------------------------------------
module sfa_ctrl #(
	parameter int LANES = sfa_pkg::LANES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [sfa_pkg::CMD_W-1:0]           cmd,
	output logic                                     busy,
	output logic                                     done,
	output sfa_pkg::ctl_t                            ctl,
	output logic [sfa_pkg::addr_w(LANES)-1:0]        idx
);

	localparam int IW = sfa_pkg::addr_w(LANES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          done_q;
	logic          accept;
	logic          slot_cmd;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign slot_cmd = (cmd == sfa_pkg::CMD_REFRESH) || (cmd == sfa_pkg::CMD_ADD) ||
	                  (cmd == sfa_pkg::CMD_SUB) || (cmd == sfa_pkg::CMD_COPY) ||
	                  (cmd == sfa_pkg::CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= slot_cmd ? ST_SWEEP : ST_LOAD;
					end
				end
				ST_LOAD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (idx_q == IW'(LANES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign idx       = idx_q;
	assign ctl.latch = accept;
	assign ctl.load  = (state_q == ST_LOAD);
	assign ctl.rd    = (state_q == ST_SWEEP);

endmodule
`default_nettype wire

[rtl/core/sfa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_datapath: stores and lane arithmetic
// Weight, bias and slot RAMs, request registers, one-lane add/sub stage.
// ----------------------------------------------------------------------------
module sfa_datapath #(
	parameter int FEATURES = sfa_pkg::FEATURES_DEF,
	parameter int LANES    = sfa_pkg::LANES_DEF,
	parameter int SLOTS    = sfa_pkg::SLOTS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire sfa_pkg::ctl_t                           ctl,
	input  wire logic [sfa_pkg::addr_w(LANES)-1:0]       idx,
	input  wire logic [sfa_pkg::CMD_W-1:0]               cmd,
	input  wire logic [sfa_pkg::FEATURE_W-1:0]           feature,
	input  wire logic [sfa_pkg::LANE_W-1:0]              lane,
	input  wire logic signed [sfa_pkg::DATA_W-1:0]       value,
	input  wire logic [sfa_pkg::SLOT_W-1:0]              src_slot,
	input  wire logic [sfa_pkg::SLOT_W-1:0]              dst_slot,
	output logic signed [sfa_pkg::DATA_W-1:0]            lane_value
);

	localparam int DW       = sfa_pkg::DATA_W;
	localparam int IW       = sfa_pkg::addr_w(LANES);
	localparam int WT_DEPTH = FEATURES * LANES;
	localparam int WT_AW    = sfa_pkg::addr_w(WT_DEPTH);
	localparam int AC_DEPTH = SLOTS * LANES;
	localparam int AC_AW    = sfa_pkg::addr_w(AC_DEPTH);

	// request registers
	logic [sfa_pkg::CMD_W-1:0]     cmd_q;
	logic [sfa_pkg::FEATURE_W-1:0] feature_q;
	logic [sfa_pkg::LANE_W-1:0]    lane_q;
	logic [DW-1:0]                 value_q;
	logic [sfa_pkg::SLOT_W-1:0]    src_q;
	logic [sfa_pkg::SLOT_W-1:0]    dst_q;

	logic          rd_s1;
	logic [IW-1:0] idx_s1;
	logic [DW-1:0] res_q;

	logic feat_ok, lane_ok, src_ok, dst_ok;
	logic is_read, is_refresh, is_arith, is_sub, slot_wr;
	logic [sfa_pkg::SLOT_W-1:0] rd_slot;
	logic rd_slot_ok;

	logic             wt_we, bias_we, acc_we;
	logic [WT_AW-1:0] wt_waddr, wt_raddr;
	logic [IW-1:0]    bias_waddr;
	logic [AC_AW-1:0] acc_waddr, acc_raddr;
	logic [DW-1:0]    wt_rdata, bias_rdata, acc_rdata;
	logic [DW-1:0]    base, addend, sum;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q     <= cmd;
			feature_q <= feature;
			lane_q    <= lane;
			value_q   <= value;
			src_q     <= src_slot;
			dst_q     <= dst_slot;
		end
	end

	assign feat_ok = int'(feature_q) < FEATURES;
	assign lane_ok = int'(lane_q) < LANES;
	assign src_ok  = int'(src_q) < SLOTS;
	assign dst_ok  = int'(dst_q) < SLOTS;

	assign is_read    = (cmd_q == sfa_pkg::CMD_READ);
	assign is_refresh = (cmd_q == sfa_pkg::CMD_REFRESH);
	assign is_sub     = (cmd_q == sfa_pkg::CMD_SUB);
	assign is_arith   = (cmd_q == sfa_pkg::CMD_ADD) || is_sub;
	assign slot_wr    = is_refresh || is_arith || (cmd_q == sfa_pkg::CMD_COPY);

	// read reports the destination, everything else reads the source
	assign rd_slot    = is_read ? dst_q : src_q;
	assign rd_slot_ok = is_read ? dst_ok : src_ok;

	// load path
	assign wt_we      = ctl.load && (cmd_q == sfa_pkg::CMD_LD_WEIGHT) && feat_ok && lane_ok;
	assign bias_we    = ctl.load && (cmd_q == sfa_pkg::CMD_LD_BIAS) && lane_ok;
	assign wt_waddr   = WT_AW'(int'(feature_q) * LANES + int'(lane_q));
	assign bias_waddr = IW'(lane_q);

	// sweep read addresses
	assign wt_raddr  = WT_AW'(int'(feature_q) * LANES + int'(idx));
	assign acc_raddr = AC_AW'(int'(rd_slot) * LANES + int'(idx));

	// lane stage
	always_comb begin
		if (is_refresh) begin
			base = bias_rdata;
		end else if (rd_slot_ok) begin
			base = acc_rdata;
		end else begin
			base = '0;
		end
	end

	assign addend    = (is_arith && feat_ok) ? wt_rdata : '0;
	assign sum       = is_sub ? (base - addend) : (base + addend);
	assign acc_we    = rd_s1 && dst_ok && slot_wr;
	assign acc_waddr = AC_AW'(int'(dst_q) * LANES + int'(idx_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctl.rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		if (ctl.latch) begin
			res_q <= '0;
		end else if (ctl.load) begin
			res_q <= ((cmd_q == sfa_pkg::CMD_LD_WEIGHT) || (cmd_q == sfa_pkg::CMD_LD_BIAS)) ?
			         value_q : '0;
		end else if (rd_s1 && dst_ok && lane_ok && (int'(idx_s1) == int'(lane_q))) begin
			res_q <= sum;
		end
	end

	assign lane_value = res_q;

	sfa_ram #(.WIDTH(DW), .DEPTH(WT_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (value_q),
		.re    (ctl.rd),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	sfa_ram #(.WIDTH(DW), .DEPTH(LANES)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (bias_waddr),
		.wdata (value_q),
		.re    (ctl.rd),
		.raddr (idx),
		.rdata (bias_rdata)
	);

	sfa_ram #(.WIDTH(DW), .DEPTH(AC_DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (sum),
		.re    (ctl.rd),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

endmodule
`default_nettype wire

[rtl/core/sparse_feature_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_feature_accumulator: incremental first-layer accumulator
// Weight store, bias row and accumulator slots updated one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   fields cmd, feature, lane, value, src_slot and dst_slot travel with it.
//   Every request returns exactly one lane_value, shown for one cycle while
//   done is high; the receiver has no back-pressure and must take it then.
//   Loads (weight, bias) and the unused code go through the load state to
//   the done cycle. Slot requests (refresh, add, subtract, copy, read) sweep
//   the row one lane per cycle through the slot RAM's read and write ports,
//   then go through the drain state to the done cycle.
//   busy drops in the done cycle, so the next request can be taken there;
//   no request is taken while an earlier one is still in flight.
//   Lane sums wrap modulo 2^16. Out-of-range features, lanes and slots
//   behave as zero rows or suppressed writes.
//   Reset clears the sequencer and the datapath's sweep flag; the weight, bias
//   and slot RAMs come up undefined and must be written before they are read.
// ----------------------------------------------------------------------------
module sparse_feature_accumulator #(
	parameter int FEATURES = sfa_pkg::FEATURES_DEF,
	parameter int LANES    = sfa_pkg::LANES_DEF,
	parameter int SLOTS    = sfa_pkg::SLOTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [sfa_pkg::CMD_W-1:0]           cmd,
	input  wire logic [sfa_pkg::FEATURE_W-1:0]       feature,
	input  wire logic [sfa_pkg::LANE_W-1:0]          lane,
	input  wire logic signed [sfa_pkg::DATA_W-1:0]   value,
	input  wire logic [sfa_pkg::SLOT_W-1:0]          src_slot,
	input  wire logic [sfa_pkg::SLOT_W-1:0]          dst_slot,
	output logic                                     done,
	output logic signed [sfa_pkg::DATA_W-1:0]        lane_value
);

	// sequencer command bundle and current sweep lane
	sfa_pkg::ctl_t                    ctl;
	logic [sfa_pkg::addr_w(LANES)-1:0] idx;

	sfa_ctrl #(.LANES(LANES)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.idx    (idx)
	);

	// stores plus the one-lane read-modify-write stage
	sfa_datapath #(
		.FEATURES (FEATURES),
		.LANES    (LANES),
		.SLOTS    (SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.idx        (idx),
		.cmd        (cmd),
		.feature    (feature),
		.lane       (lane),
		.value      (value),
		.src_slot   (src_slot),
		.dst_slot   (dst_slot),
		.lane_value (lane_value)
	);

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sparse_feature_accumulator
// Drives load, refresh, add, subtract, copy, read and unused-code requests in
// bursts and checks every lane_value strobe against a lane-accurate software
// copy of the weight store, bias row and accumulator slots or a pinned answer.
// ----------------------------------------------------------------------------
module testbench;
	import sfa_pkg::*;

	localparam int FEATURES     = FEATURES_DEF;
	localparam int LANES        = LANES_DEF;
	localparam int SLOTS        = SLOTS_DEF;
	localparam int POOL         = 8;       // weight rows the random part works on
	localparam int RANDOM_ITEMS = 1330;
	localparam int IDLE_LIMIT   = 2000;    // cycles with no request or result
	localparam int DRAIN_CYCLES = LANES + 4;

	// the package has no name for code 7; the block answers it with zero
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [FEATURE_W-1:0] feature;
		logic [LANE_W-1:0]    lane;
		word_t                value;
		logic [SLOT_W-1:0]    src_slot;
		logic [SLOT_W-1:0]    dst_slot;
	} request_t;

	// pinned rows carry a typed-in answer; the others go through the predictor
	typedef struct packed {
		request_t req;
		logic     pinned;
		word_t    pinned_value;
	} directed_row_t;

	localparam int NUM_DIRECTED = 23;

	// Assumes the bias row and weight rows 0 and 767 are already full, and
	// leaves every slot written, so the random part can read any of them.
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		// unused code: all-ones and all-zeros fields, answer is zero
		'{'{CMD_UNUSED,    10'h3ff, 4'hf, 16'hffff, 3'd7, 3'd7}, 1'b1, 16'h0000},
		'{'{CMD_UNUSED,    10'h000, 4'h0, 16'h0000, 3'd0, 3'd0}, 1'b1, 16'h0000},
		// weight loads: feature past the store, then the value extremes
		'{'{CMD_LD_WEIGHT, 10'd768, 4'h3, 16'h3039, 3'd0, 3'd0}, 1'b1, 16'h3039},
		'{'{CMD_LD_WEIGHT, 10'h3ff, 4'hf, 16'h8000, 3'd7, 3'd7}, 1'b1, 16'h8000},
		'{'{CMD_LD_WEIGHT, 10'd767, 4'hf, 16'h7fff, 3'd0, 3'd0}, 1'b1, 16'h7fff},
		'{'{CMD_LD_WEIGHT, 10'd0,   4'h0, 16'h8000, 3'd0, 3'd0}, 1'b1, 16'h8000},
		// bias loads at both ends of the row
		'{'{CMD_LD_BIAS,   10'h3ff, 4'hf, 16'hffff, 3'd5, 3'd2}, 1'b1, 16'hffff},
		'{'{CMD_LD_BIAS,   10'd0,   4'h0, 16'h7fff, 3'd0, 3'd0}, 1'b1, 16'h7fff},
		// refresh the first and last slot
		'{'{CMD_REFRESH,   10'd0,   4'h0, 16'h0000, 3'd7, 3'd0}, 1'b0, 16'h0000},
		'{'{CMD_REFRESH,   10'h3ff, 4'hf, 16'hffff, 3'd0, 3'd7}, 1'b0, 16'h0000},
		// 0x7fff + 0x8000 in lane 0, then an in-place add
		'{'{CMD_ADD,       10'd0,   4'h0, 16'h0000, 3'd0, 3'd1}, 1'b0, 16'h0000},
		'{'{CMD_ADD,       10'd767, 4'hf, 16'h0000, 3'd1, 3'd1}, 1'b0, 16'h0000},
		'{'{CMD_SUB,       10'd767, 4'hf, 16'h0000, 3'd7, 3'd2}, 1'b0, 16'h0000},
		'{'{CMD_SUB,       10'd0,   4'h0, 16'h0000, 3'd2, 3'd2}, 1'b0, 16'h0000},
		// feature past the store: add and subtract turn into a copy
		'{'{CMD_ADD,       10'd768, 4'h5, 16'h0000, 3'd0, 3'd3}, 1'b0, 16'h0000},
		'{'{CMD_SUB,       10'h3ff, 4'h9, 16'h0000, 3'd3, 3'd4}, 1'b0, 16'h0000},
		'{'{CMD_COPY,      10'd0,   4'h1, 16'h0000, 3'd4, 3'd5}, 1'b0, 16'h0000},
		'{'{CMD_COPY,      10'd5,   4'h2, 16'h0000, 3'd5, 3'd5}, 1'b0, 16'h0000},
		'{'{CMD_REFRESH,   10'd0,   4'h7, 16'h0000, 3'd0, 3'd6}, 1'b0, 16'h0000},
		'{'{CMD_READ,      10'd0,   4'h0, 16'h0000, 3'd0, 3'd1}, 1'b0, 16'h0000},
		'{'{CMD_READ,      10'h3ff, 4'hf, 16'hffff, 3'd7, 3'd2}, 1'b0, 16'h0000},
		'{'{CMD_COPY,      10'd0,   4'h7, 16'h0000, 3'd6, 3'd0}, 1'b0, 16'h0000},
		'{'{CMD_READ,      10'd0,   4'h7, 16'h0000, 3'd0, 3'd0}, 1'b0, 16'h0000}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CMD_W-1:0]     cmd;
	logic [FEATURE_W-1:0] feature;
	logic [LANE_W-1:0]    lane;
	logic signed [DATA_W-1:0] value;
	logic [SLOT_W-1:0]    src_slot;
	logic [SLOT_W-1:0]    dst_slot;
	logic                 done;
	logic signed [DATA_W-1:0] lane_value;

	sparse_feature_accumulator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.feature    (feature),
		.lane       (lane),
		.value      (value),
		.src_slot   (src_slot),
		.dst_slot   (dst_slot),
		.done       (done),
		.lane_value (lane_value)
	);

	// ---- software copy of the block's stores ------------------------------
	word_t            weight_mem [FEATURES][LANES];
	logic [LANES-1:0] weight_lanes_set [FEATURES];  // which lanes were loaded
	word_t            bias_mem [LANES];
	logic [LANES-1:0] bias_lanes_set;
	word_t            slot_mem [SLOTS][LANES];
	logic [SLOTS-1:0] slot_set;

	word_t            lane_values_due [$];  // oldest outstanding answer first
	logic [FEATURE_W-1:0] feature_pool [POOL];
	int               fail_count  = 0;
	int               idle_cycles = 0;
	int               burst_left  = 0;

	// Applies one request to the copy of the stores and returns its lane_value.
	function automatic word_t accumulate_step(input request_t r);
		word_t row [LANES];
		word_t result;
		result = '0;
		case (r.cmd)
			CMD_LD_WEIGHT: begin
				if (r.feature < FEATURES && r.lane < LANES) begin
					weight_mem[r.feature][r.lane] = r.value;
					weight_lanes_set[r.feature][r.lane] = 1'b1;
				end
				result = r.value;
			end
			CMD_LD_BIAS: begin
				if (r.lane < LANES) begin
					bias_mem[r.lane] = r.value;
					bias_lanes_set[r.lane] = 1'b1;
				end
				result = r.value;
			end
			CMD_REFRESH, CMD_ADD, CMD_SUB, CMD_COPY: begin
				// out-of-range source reads as zeros
				for (int i = 0; i < LANES; i++)
					row[i] = (r.cmd == CMD_REFRESH) ? bias_mem[i] :
						(r.src_slot < SLOTS) ? slot_mem[r.src_slot][i] : '0;
				// a feature past the store contributes a zero row
				if ((r.cmd == CMD_ADD || r.cmd == CMD_SUB) && r.feature < FEATURES)
					for (int i = 0; i < LANES; i++)
						row[i] = (r.cmd == CMD_ADD) ? row[i] + weight_mem[r.feature][i]
							: row[i] - weight_mem[r.feature][i];
				if (r.dst_slot < SLOTS) begin
					for (int i = 0; i < LANES; i++)
						slot_mem[r.dst_slot][i] = row[i];
					slot_set[r.dst_slot] = 1'b1;
					if (r.lane < LANES)
						result = slot_mem[r.dst_slot][r.lane];
				end
			end
			CMD_READ: begin
				if (r.dst_slot < SLOTS && r.lane < LANES)
					result = slot_mem[r.dst_slot][r.lane];
			end
			default: result = '0;
		endcase
		return result;
	endfunction

	// Sends one request in the current burst, possibly after a gap, and logs
	// the answer due for it once the block has taken it.
	task automatic issue(input request_t r, input logic pinned, input word_t pinned_value);
		int    gap;
		word_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd      <= r.cmd;
		feature  <= r.feature;
		lane     <= r.lane;
		value    <= r.value;
		src_slot <= r.src_slot;
		dst_slot <= r.dst_slot;
		start    <= 1'b1;
		// busy read here is the value the edge just sampled
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = accumulate_step(r);
		lane_values_due.push_back(pinned ? pinned_value : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---- result checker and watchdog ---------------------------------------
	// Results cannot be held off, so every done cycle must match the oldest
	// outstanding request. The watchdog only counts cycles with neither a
	// request taken nor a result shown.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (lane_values_due.size() == 0) begin
					$error("lane_value %0d with no request outstanding", lane_value);
					fail_count++;
				end else begin
					if (lane_value !== lane_values_due[0]) begin
						$error("lane_value mismatch: expected %0d, got %0d",
							$signed(lane_values_due[0]), lane_value);
						fail_count++;
					end
					void'(lane_values_due.pop_front());
				end
			end
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// ---- stimulus ----------------------------------------------------------
	initial begin
		request_t r;
		int       pick;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd      <= '0;
		feature  <= '0;
		lane     <= '0;
		value    <= '0;
		src_slot <= '0;
		dst_slot <= '0;
		for (int f = 0; f < FEATURES; f++)
			weight_lanes_set[f] = '0;
		bias_lanes_set = '0;
		slot_set = '0;
		feature_pool[0] = '0;
		feature_pool[1] = FEATURE_W'(FEATURES - 1);
		for (int p = 2; p < POOL; p++)
			feature_pool[p] = FEATURE_W'($urandom_range(1, FEATURES - 2));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Preload: full bias row and weight rows 0 and 767, extremes at the
		// row ends, so refresh, add and subtract have defined data to use.
		for (int i = 0; i < LANES * 3; i++) begin
			r.feature  = FEATURE_W'($urandom);
			r.src_slot = SLOT_W'($urandom);
			r.dst_slot = SLOT_W'($urandom);
			r.lane     = LANE_W'(i % LANES);
			r.value    = (r.lane == 0) ? 16'h7fff : (r.lane == LANES - 1) ? 16'h8000
				: word_t'($urandom);
			if (i < LANES) begin
				r.cmd = CMD_LD_BIAS;
			end else begin
				r.cmd     = CMD_LD_WEIGHT;
				r.feature = feature_pool[i / LANES - 1];
			end
			issue(r, 1'b0, '0);
		end

		for (int i = 0; i < NUM_DIRECTED; i++)
			issue(DIRECTED[i].req, DIRECTED[i].pinned, DIRECTED[i].pinned_value);

		// Random part: mostly loads onto a small pool of rows so they fill up,
		// and slot updates from full rows; a little noise beside that.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r.feature  = FEATURE_W'($urandom);
			r.lane     = LANE_W'($urandom);
			r.value    = word_t'($urandom);
			r.src_slot = SLOT_W'($urandom);
			r.dst_slot = SLOT_W'($urandom);
			if ($urandom_range(0, 7) == 0)
				case ($urandom_range(0, 3))
					0: r.value = 16'h8000;
					1: r.value = 16'h7fff;
					2: r.value = 16'hffff;
					default: r.value = 16'h0000;
				endcase
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				r.cmd = CMD_LD_WEIGHT;
				if ($urandom_range(0, 7) != 0) begin
					r.feature = feature_pool[$urandom_range(0, POOL - 1)];
					// half the time fill the lowest gap of a partial row
					if (weight_lanes_set[r.feature] != '1 && $urandom_range(0, 1) == 1)
						for (int i = LANES - 1; i >= 0; i--)
							if (!weight_lanes_set[r.feature][i])
								r.lane = LANE_W'(i);
				end
			end else if (pick < 30) begin
				r.cmd = CMD_LD_BIAS;
			end else if (pick < 40) begin
				r.cmd = CMD_REFRESH;
			end else if (pick < 75) begin
				r.cmd = (pick < 58) ? CMD_ADD : CMD_SUB;
				if ($urandom_range(0, 9) == 0) begin
					r.feature = FEATURE_W'($urandom_range(FEATURES, (1 << FEATURE_W) - 1));
				end else begin
					r.feature = feature_pool[$urandom_range(0, POOL - 1)];
					// a partial row must never be read; row 0 is always full
					if (weight_lanes_set[r.feature] != '1)
						r.feature = feature_pool[0];
				end
			end else if (pick < 85) begin
				r.cmd = CMD_COPY;
			end else if (pick < 95) begin
				r.cmd = CMD_READ;
			end else begin
				r.cmd = CMD_UNUSED;
			end
			issue(r, 1'b0, '0);
		end

		start <= 1'b0;
		while (lane_values_due.size() != 0)
			@(posedge clk);
		// any stray strobe in this window is flagged by the checker
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/core/sfa_pkg.sv
rtl/core/sfa_ram.sv
rtl/core/sfa_ctrl.sv
rtl/core/sfa_datapath.sv
rtl/core/sparse_feature_accumulator.sv
tb/testbench.sv
